// File: hdl/sp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sp_pkg;

    localparam int SAMPLE_DEPTH_DEFAULT = 65536;

    localparam int SAMPLE_W    = 16;
    localparam int TICK_W      = 24;
    localparam int POS_W       = 18;
    localparam int COUNT_W     = 17;
    localparam int PITCH_W     = 8;
    localparam int CFG_W       = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int LANE_STEPS  = SAMPLE_W;
    localparam int STEP_W      = $clog2(LANE_STEPS);

    localparam logic [TICK_W-1:0]  ATTACK_RESET   = 24'd2205;
    localparam logic [TICK_W-1:0]  RELEASE_RESET  = 24'd2205;
    localparam logic [TICK_W-1:0]  DURATION_RESET = 24'd44100;
    localparam logic [COUNT_W-1:0] COUNT_RESET    = 17'd0;
    localparam logic [PITCH_W-1:0] PITCH_RESET    = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PITCH    = 3'd4;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_START    = 2'd1;
    localparam logic [1:0] OP_GENERATE = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    typedef struct packed {
        logic [1:0]                 operation;
        logic [15:0]                load_address;
        logic signed [SAMPLE_W-1:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       playing;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] num;
        logic [TICK_W-1:0] den;
    } lane_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_L,
        ST_READ_R,
        ST_TAKE_R,
        ST_SCALE
    } gen_state_t;

    typedef enum logic [1:0] {
        ENV_ATTACK,
        ENV_RELEASE,
        ENV_SUSTAIN,
        ENV_ENDED
    } env_mode_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIV,
        LN_DONE
    } lane_state_t;

endpackage

`default_nettype wire

// File: hdl/sp_scale_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module sp_scale_lane
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sp_pkg::lane_cmd_t                   cmd,
    input  wire logic signed [sp_pkg::SAMPLE_W-1:0]  sample,
    output logic                                     done,
    output logic signed [sp_pkg::SAMPLE_W-1:0]       scaled
);

    sp_pkg::lane_state_t state_reg;
    sp_pkg::lane_state_t state_next;

    logic [sp_pkg::STEP_W-1:0]   cnt_reg;
    logic [sp_pkg::TICK_W-1:0]   hi_reg;
    logic [sp_pkg::SAMPLE_W-1:0] lo_reg;
    logic [sp_pkg::SAMPLE_W-1:0] mag_reg;
    logic                        neg_reg;
    logic [sp_pkg::TICK_W-1:0]   num_reg;
    logic [sp_pkg::TICK_W-1:0]   den_reg;

    logic                        last_step;
    logic [sp_pkg::TICK_W:0]     mul_sum;
    logic [sp_pkg::TICK_W:0]     trial;
    logic [sp_pkg::TICK_W:0]     diff;
    logic                        ge;

    assign last_step = (cnt_reg == sp_pkg::STEP_W'(sp_pkg::LANE_STEPS - 1));

    // The product is built LSB first: the low half shifts out of the adder one bit a cycle.
    assign mul_sum = {1'b0, hi_reg} + (mag_reg[0] ? {1'b0, num_reg} : '0);

    // Restoring division of the product by the denominator, one quotient bit a cycle.
    assign trial = {hi_reg, lo_reg[sp_pkg::SAMPLE_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sp_pkg::LN_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = sp_pkg::LN_MUL;
                end
            end
            sp_pkg::LN_MUL:
            begin
                if (last_step)
                begin
                    state_next = sp_pkg::LN_DIV;
                end
            end
            sp_pkg::LN_DIV:
            begin
                if (last_step)
                begin
                    state_next = sp_pkg::LN_DONE;
                end
            end
            sp_pkg::LN_DONE:
            begin
                state_next = sp_pkg::LN_IDLE;
            end
            default:
            begin
                state_next = sp_pkg::LN_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done = 1'b0;
        unique case (state_reg)
            sp_pkg::LN_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign scaled = neg_reg ? -$signed(lo_reg) : $signed(lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sp_pkg::LN_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sp_pkg::LN_MUL || state_reg == sp_pkg::LN_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sp_pkg::LN_IDLE && cmd.start)
        begin
            neg_reg <= sample[sp_pkg::SAMPLE_W-1];
            mag_reg <= sample[sp_pkg::SAMPLE_W-1] ? -sample : sample;
            num_reg <= cmd.num;
            den_reg <= cmd.den;
            hi_reg  <= '0;
            lo_reg  <= '0;
        end
        else if (state_reg == sp_pkg::LN_MUL)
        begin
            hi_reg  <= mul_sum[sp_pkg::TICK_W:1];
            lo_reg  <= {mul_sum[0], lo_reg[sp_pkg::SAMPLE_W-1:1]};
            mag_reg <= {1'b0, mag_reg[sp_pkg::SAMPLE_W-1:1]};
        end
        else if (state_reg == sp_pkg::LN_DIV)
        begin
            hi_reg <= ge ? diff[sp_pkg::TICK_W-1:0] : trial[sp_pkg::TICK_W-1:0];
            lo_reg <= {lo_reg[sp_pkg::SAMPLE_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// File: hdl/sample_player_ar_envelope_core.sv
// Load, start and no-operation items give no result; busy stays low after them.
// A generate item gives one result: done is registered from state READ_L (ended note),
// TAKE_R (sustain) or SCALE when the lanes finish (attack or release); busy is high until then.
// The envelope path is set by a shift-add multiply and a restoring divide, 16 steps each.
// A new item may be accepted in the cycle in which done is high; the receiver cannot stall.
// Reset clears position and tick count and sets the settings to their defaults; the sample memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sample_player_ar_envelope_core
#(
    parameter int SAMPLE_DEPTH = sp_pkg::SAMPLE_DEPTH_DEFAULT
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire sp_pkg::in_item_t                   item,
    output logic                                    done,
    output sp_pkg::out_item_t                       result,
    input  wire logic                               cfg_write,
    input  wire logic [sp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sp_pkg::CFG_W-1:0]           cfg_data
);

    localparam int ADDR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

    sp_pkg::gen_state_t state_reg;
    sp_pkg::gen_state_t state_next;

    logic [sp_pkg::TICK_W-1:0]   attack_reg;
    logic [sp_pkg::TICK_W-1:0]   release_reg;
    logic [sp_pkg::TICK_W-1:0]   duration_reg;
    logic [sp_pkg::COUNT_W-1:0]  count_reg;
    logic [sp_pkg::PITCH_W-1:0]  pitch_reg;

    logic [sp_pkg::POS_W-1:0]    pos_reg;
    logic [sp_pkg::TICK_W-1:0]   ticks_reg;

    logic [sp_pkg::SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
    logic [sp_pkg::SAMPLE_W-1:0] rd_data_reg;

    sp_pkg::env_mode_t           mode_reg;
    logic [sp_pkg::TICK_W-1:0]   num_reg;
    logic [sp_pkg::TICK_W-1:0]   den_reg;
    logic                        in_l_reg;
    logic                        in_r_reg;
    logic [sp_pkg::SAMPLE_W-1:0] left_reg;

    logic                        done_reg;
    sp_pkg::out_item_t           result_reg;

    logic                        accept;
    logic                        load_we;
    logic                        rd_en;
    logic                        decide_en;
    logic                        left_en;
    logic                        lane_go;
    logic                        emit_ended;
    logic                        emit_direct;
    logic                        emit_scaled;
    logic                        advance;

    logic [sp_pkg::POS_W:0]      pos_l;
    logic [sp_pkg::POS_W:0]      pos_r;
    logic [sp_pkg::POS_W:0]      pos_sum;
    logic [ADDR_W-1:0]           rd_addr;
    logic [sp_pkg::TICK_W:0]     release_end;
    logic                        is_attack;
    logic                        is_release;
    logic                        is_sustain;
    sp_pkg::env_mode_t           mode_now;
    logic [sp_pkg::SAMPLE_W-1:0] right_now;

    sp_pkg::lane_cmd_t           lane_cmd;
    logic                        lane_done_l;
    logic                        lane_done_r;
    logic signed [sp_pkg::SAMPLE_W-1:0] scaled_l;
    logic signed [sp_pkg::SAMPLE_W-1:0] scaled_r;

    assign busy   = (state_reg != sp_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign load_we = accept && (item.operation == sp_pkg::OP_LOAD)
                     && (int'(item.load_address) < SAMPLE_DEPTH);

    assign pos_l   = {1'b0, pos_reg};
    assign pos_r   = pos_l + 1'b1;
    assign pos_sum = pos_l + {{(sp_pkg::POS_W + 1 - sp_pkg::PITCH_W){1'b0}}, pitch_reg} + 2'd2;
    assign rd_addr = (state_reg == sp_pkg::ST_READ_L) ? ADDR_W'(pos_l) : ADDR_W'(pos_r);

    assign release_end = {1'b0, ticks_reg} + {1'b0, release_reg};
    assign is_attack   = (ticks_reg < attack_reg);
    assign is_release  = (release_end > {1'b0, duration_reg}) && (ticks_reg < duration_reg);
    assign is_sustain  = (pos_l < {2'b0, count_reg}) && (ticks_reg < duration_reg);

    always_comb
    begin
        if (is_attack)
        begin
            mode_now = sp_pkg::ENV_ATTACK;
        end
        else if (is_release)
        begin
            mode_now = sp_pkg::ENV_RELEASE;
        end
        else if (is_sustain)
        begin
            mode_now = sp_pkg::ENV_SUSTAIN;
        end
        else
        begin
            mode_now = sp_pkg::ENV_ENDED;
        end
    end

    assign right_now = in_r_reg ? rd_data_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sp_pkg::ST_IDLE:
            begin
                if (accept && item.operation == sp_pkg::OP_GENERATE)
                begin
                    state_next = sp_pkg::ST_READ_L;
                end
            end
            sp_pkg::ST_READ_L:
            begin
                state_next = (mode_now == sp_pkg::ENV_ENDED) ? sp_pkg::ST_IDLE
                                                             : sp_pkg::ST_READ_R;
            end
            sp_pkg::ST_READ_R:
            begin
                state_next = sp_pkg::ST_TAKE_R;
            end
            sp_pkg::ST_TAKE_R:
            begin
                state_next = (mode_reg == sp_pkg::ENV_SUSTAIN) ? sp_pkg::ST_IDLE
                                                               : sp_pkg::ST_SCALE;
            end
            sp_pkg::ST_SCALE:
            begin
                if (lane_done_l)
                begin
                    state_next = sp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en       = 1'b0;
        decide_en   = 1'b0;
        left_en     = 1'b0;
        lane_go     = 1'b0;
        emit_ended  = 1'b0;
        emit_direct = 1'b0;
        emit_scaled = 1'b0;
        unique case (state_reg)
            sp_pkg::ST_IDLE:
            begin
            end
            sp_pkg::ST_READ_L:
            begin
                rd_en      = 1'b1;
                decide_en  = 1'b1;
                emit_ended = (mode_now == sp_pkg::ENV_ENDED);
            end
            sp_pkg::ST_READ_R:
            begin
                rd_en   = 1'b1;
                left_en = 1'b1;
            end
            sp_pkg::ST_TAKE_R:
            begin
                emit_direct = (mode_reg == sp_pkg::ENV_SUSTAIN);
                lane_go     = (mode_reg != sp_pkg::ENV_SUSTAIN);
            end
            sp_pkg::ST_SCALE:
            begin
                emit_scaled = lane_done_l;
            end
            default:
            begin
            end
        endcase
    end

    assign advance = emit_direct || emit_scaled;

    assign lane_cmd.start = lane_go;
    assign lane_cmd.num   = num_reg;
    assign lane_cmd.den   = den_reg;

    sp_scale_lane u_lane_l
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (lane_cmd),
        .sample (left_reg),
        .done   (lane_done_l),
        .scaled (scaled_l)
    );

    sp_scale_lane u_lane_r
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (lane_cmd),
        .sample (right_now),
        .done   (lane_done_r),
        .scaled (scaled_r)
    );

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[ADDR_W'(item.load_address)] <= item.load_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sp_pkg::ST_IDLE;
            attack_reg   <= sp_pkg::ATTACK_RESET;
            release_reg  <= sp_pkg::RELEASE_RESET;
            duration_reg <= sp_pkg::DURATION_RESET;
            count_reg    <= sp_pkg::COUNT_RESET;
            pitch_reg    <= sp_pkg::PITCH_RESET;
            pos_reg      <= '0;
            ticks_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit_ended || advance;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    sp_pkg::CFG_ATTACK:   attack_reg   <= cfg_data;
                    sp_pkg::CFG_RELEASE:  release_reg  <= cfg_data;
                    sp_pkg::CFG_DURATION: duration_reg <= cfg_data;
                    sp_pkg::CFG_COUNT:    count_reg    <= cfg_data[sp_pkg::COUNT_W-1:0];
                    sp_pkg::CFG_PITCH:    pitch_reg    <= cfg_data[sp_pkg::PITCH_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept && item.operation == sp_pkg::OP_START)
            begin
                pos_reg   <= '0;
                ticks_reg <= '0;
            end
            else if (advance)
            begin
                pos_reg   <= pos_sum[sp_pkg::POS_W] ? '1 : pos_sum[sp_pkg::POS_W-1:0];
                ticks_reg <= ticks_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide_en)
        begin
            mode_reg <= mode_now;
            in_l_reg <= (pos_l < {2'b0, count_reg}) && (int'(pos_l) < SAMPLE_DEPTH);
            in_r_reg <= (pos_r < {2'b0, count_reg}) && (int'(pos_r) < SAMPLE_DEPTH);
            if (is_attack)
            begin
                num_reg <= ticks_reg;
                den_reg <= attack_reg;
            end
            else
            begin
                num_reg <= duration_reg - ticks_reg;
                den_reg <= release_reg;
            end
        end

        if (left_en)
        begin
            left_reg <= in_l_reg ? rd_data_reg : '0;
        end

        if (emit_ended)
        begin
            result_reg.left_sample  <= '0;
            result_reg.right_sample <= '0;
            result_reg.playing      <= 1'b0;
        end
        else if (emit_direct)
        begin
            result_reg.left_sample  <= left_reg;
            result_reg.right_sample <= right_now;
            result_reg.playing      <= 1'b1;
        end
        else if (emit_scaled && lane_done_r)
        begin
            result_reg.left_sample  <= scaled_l;
            result_reg.right_sample <= scaled_r;
            result_reg.playing      <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_sample_player_ar_envelope_core.sv
`timescale 1ns / 1ps

module tb_sample_player_ar_envelope_core;

    import sp_pkg::*;

    localparam int DEPTH        = SAMPLE_DEPTH_DEFAULT;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 700;
    localparam int MAX_REPORTS  = 10;

    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);
    localparam logic [PITCH_W-1:0] PITCH_MAX = '1;
    localparam logic [POS_W-1:0]   POS_LIMIT = '1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    in_item_t               item;
    logic                   done;
    out_item_t              result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    logic signed [SAMPLE_W-1:0] word_mem [DEPTH];
    bit                         word_loaded [DEPTH];
    logic [POS_W-1:0]           play_pos;
    logic [TICK_W-1:0]          tick_count;
    logic [TICK_W-1:0]          attack_len;
    logic [TICK_W-1:0]          release_len;
    logic [TICK_W-1:0]          note_len;
    logic [COUNT_W-1:0]         word_count;
    logic [PITCH_W-1:0]         pitch_skip;

    out_item_t pending_frames [$];
    out_item_t want_frame;
    int        error_count  = 0;
    int        items_sent   = 0;
    int        quiet_cycles = 0;
    bit        no_gaps      = 1'b0;

    sample_player_ar_envelope_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [SAMPLE_W-1:0] stored_word(logic [POS_W:0] idx);
        if (idx >= word_count || idx >= DEPTH)
            return '0;
        return word_mem[idx[15:0]];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] ramp(logic signed [SAMPLE_W-1:0] s,
                                                        logic [TICK_W-1:0] num,
                                                        logic [TICK_W-1:0] den);
        longint prod;
        prod = longint'(s) * longint'(num);
        return SAMPLE_W'(prod / longint'(den));
    endfunction

    function automatic bit play_item(in_item_t it, output out_item_t frame);
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [POS_W:0]             next_pos;
        frame = '0;
        case (it.operation)
            OP_LOAD:
            begin
                word_mem[it.load_address] = it.load_value;
                word_loaded[it.load_address] = 1'b1;
                return 1'b0;
            end
            OP_START:
            begin
                play_pos = '0;
                tick_count = '0;
                return 1'b0;
            end
            OP_GENERATE:
            begin
            end
            default:
                return 1'b0;
        endcase
        left = stored_word({1'b0, play_pos});
        right = stored_word({1'b0, play_pos} + 1'b1);
        if (tick_count < attack_len)
        begin
            left = ramp(left, tick_count, attack_len);
            right = ramp(right, tick_count, attack_len);
        end
        else if ({1'b0, tick_count} + {1'b0, release_len} > {1'b0, note_len}
                 && tick_count < note_len)
        begin
            left = ramp(left, note_len - tick_count, release_len);
            right = ramp(right, note_len - tick_count, release_len);
        end
        else if (!(play_pos < word_count && tick_count < note_len))
        begin
            return 1'b1;
        end
        next_pos = {1'b0, play_pos} + pitch_skip + 2'd2;
        play_pos = (next_pos > POS_LIMIT) ? POS_LIMIT : next_pos[POS_W-1:0];
        tick_count = tick_count + 1'b1;
        frame.left_sample = left;
        frame.right_sample = right;
        frame.playing = 1'b1;
        return 1'b1;
    endfunction

    function automatic void apply_setting(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_ATTACK:   attack_len = data;
            CFG_RELEASE:  release_len = data;
            CFG_DURATION: note_len = data;
            CFG_COUNT:    word_count = data[COUNT_W-1:0];
            CFG_PITCH:    pitch_skip = data[PITCH_W-1:0];
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_value(logic [CFG_W-1:0] top, int typical);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return top;
            default: return CFG_W'($urandom_range(0, typical));
        endcase
    endfunction

    task automatic note_error(string what, out_item_t want, out_item_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t %s: expected L=%0d R=%0d P=%0b, got L=%0d R=%0d P=%0b",
                     $time, what, want.left_sample, want.right_sample, want.playing,
                     got.left_sample, got.right_sample, got.playing);
    endtask

    task automatic send_item(in_item_t it);
        int        gap;
        out_item_t frame;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (play_item(it, frame))
            pending_frames.push_back(frame);
        items_sent++;
    endtask

    task automatic send_op(logic [1:0] op);
        in_item_t it;
        it.operation = op;
        it.load_address = 16'($urandom);
        it.load_value = 16'($urandom);
        send_item(it);
    endtask

    task automatic load_word(logic [15:0] addr, logic [15:0] value);
        in_item_t it;
        it.operation = OP_LOAD;
        it.load_address = addr;
        it.load_value = value;
        send_item(it);
    endtask

    // Words within the count that the next frame will read are loaded first, so no word it uses is an empty entry.
    task automatic make_frame();
        logic [POS_W:0] idx;
        for (int k = 0; k < 2; k++)
        begin
            idx = {1'b0, play_pos} + (POS_W + 1)'(k);
            if (idx < word_count && idx < DEPTH && !word_loaded[idx[15:0]])
                load_word(idx[15:0], 16'($urandom));
        end
        send_op(OP_GENERATE);
    endtask

    task automatic write_setting(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        apply_setting(idx, data);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_player(logic [CFG_W-1:0] att, logic [CFG_W-1:0] rel,
                              logic [CFG_W-1:0] dur, logic [CFG_W-1:0] cnt,
                              logic [CFG_W-1:0] pitch);
        write_setting(CFG_ATTACK, att);
        write_setting(CFG_RELEASE, rel);
        write_setting(CFG_DURATION, dur);
        write_setting(CFG_COUNT, cnt);
        write_setting(CFG_PITCH, pitch);
    endtask

    task automatic test_basic_envelope();
        send_op(OP_GENERATE);
        send_op(OP_GENERATE);
        send_op(OP_NOP);
        settle();
        set_player(24'd2, 24'd3, 24'd6, 24'd10, 24'd0);
        load_word(16'd2, 16'h7FFF);
        load_word(16'd3, 16'h8000);
        load_word(16'd4, 16'hFFFF);
        load_word(16'd5, 16'h0001);
        load_word(16'd6, 16'h8000);
        load_word(16'd7, 16'h7FFF);
        load_word(16'd8, 16'hFFFF);
        load_word(16'd9, 16'h8001);
        load_word(16'hFFFF, 16'h1234);
        send_op(OP_START);
        repeat (8) make_frame();
    endtask

    task automatic test_extreme_settings();
        settle();
        set_player(24'd0, TICK_MAX, TICK_MAX, CFG_W'(COUNT_MAX), CFG_W'(PITCH_MAX));
        send_op(OP_START);
        repeat (4) make_frame();
        settle();
        set_player(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        for (int i = int'(CFG_PITCH) + 1; i < (1 << CFG_INDEX_W); i++)
            write_setting(CFG_INDEX_W'(i), CFG_W'($urandom));
        send_op(OP_START);
        repeat (2) make_frame();
        settle();
        set_player(TICK_MAX, 24'd0, TICK_MAX, 24'd4, 24'd0);
        send_op(OP_START);
        repeat (3) make_frame();
    endtask

    task automatic test_random_phases();
        int goal;
        int pick;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            settle();
            set_player(pick_value(TICK_MAX, 24), pick_value(TICK_MAX, 24),
                       pick_value(TICK_MAX, 80), pick_value(CFG_W'(COUNT_MAX), 160),
                       pick_value(CFG_W'(PITCH_MAX), 6));
            no_gaps = ($urandom_range(0, 3) == 0);
            send_op(OP_START);
            repeat ($urandom_range(20, 50))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    make_frame();
                else if (pick < 78)
                    send_op(OP_LOAD);
                else if (pick < 86)
                    load_word(16'($urandom_range(0, 255)), 16'($urandom));
                else if (pick < 93)
                    send_op(OP_START);
                else
                    send_op(OP_NOP);
            end
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_frames.size() == 0)
            begin
                note_error("unexpected frame", '0, result);
            end
            else
            begin
                want_frame = pending_frames.pop_front();
                if (result.left_sample !== want_frame.left_sample
                    || result.right_sample !== want_frame.right_sample
                    || result.playing !== want_frame.playing)
                    note_error("frame mismatch", want_frame, result);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        play_pos = '0;
        tick_count = '0;
        attack_len = ATTACK_RESET;
        release_len = RELEASE_RESET;
        note_len = DURATION_RESET;
        word_count = COUNT_RESET;
        pitch_skip = PITCH_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_basic_envelope();
        test_extreme_settings();
        test_random_phases();
        settle();
        repeat (40) @(posedge clk);
        error_count += pending_frames.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
hdl/sp_pkg.sv
hdl/sp_scale_lane.sv
hdl/sample_player_ar_envelope_core.sv
tb/tb_sample_player_ar_envelope_core.sv
